@@ sv/ptlr_pkg.sv @@
// Shared types, codes and the 6-column glyph table for the text line renderer.
`default_nettype none

package ptlr_pkg;

  // Function codes carried on the input tuser
  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_CHAR  = 2'd1,
    FUNC_END   = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // Work kinds handed from the front end to the back end
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_GLYPH = 2'd1,
    KIND_SPACE = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  // Queue entry: arg is start_col for KIND_START, glyph index for KIND_GLYPH
  typedef struct packed {
    kind_t      kind;
    logic [7:0] arg;
  } q_entry_t;

  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned ROM_GLYPHS   = 96;
  localparam logic [7:0]  FIRST_CODE   = 8'h20;
  localparam logic [7:0]  END_MARK     = 8'hE3;
  localparam logic [7:0]  SPACE_BLANKS = 8'd3;

  // One row per glyph, column 0 in the top byte, column 5 in the bottom byte
  localparam logic [47:0] GLYPH_ROM [ROM_GLYPHS] = '{
    48'h000000000000, 48'h0000004F0000, 48'h000007000700, 48'h00147F147F14,
    48'h00242A7F2A12, 48'h002313086462, 48'h003649552250, 48'h000005030000,
    48'h00001C224100, 48'h000041221C00, 48'h0014083E0814, 48'h0008083E0808,
    48'h000050300000, 48'h000808080808, 48'h000060600000, 48'h002010080402,
    48'h003E5149453E, 48'h0000427F4000, 48'h004261514946, 48'h002141454B31,
    48'h001814127F10, 48'h002745454539, 48'h003C4A494930, 48'h000171090503,
    48'h003649494936, 48'h00064949291E, 48'h000036360000, 48'h000056360000,
    48'h000814224100, 48'h001414141414, 48'h000041221408, 48'h000201510906,
    48'h00324979413E, 48'h007E1111117E, 48'h007F49494936, 48'h003E41414122,
    48'h007F4141221C, 48'h007F49494941, 48'h007F09090901, 48'h003E4149497A,
    48'h007F0808087F, 48'h0000417F4100, 48'h002040413F01, 48'h007F08142241,
    48'h007F40404040, 48'h007F020C027F, 48'h007F0408107F, 48'h003E4141413E,
    48'h007F09090906, 48'h003E4151215E, 48'h007F09192946, 48'h004649494931,
    48'h0001017F0101, 48'h003F4040403F, 48'h001F2040201F, 48'h003F4038403F,
    48'h006314081463, 48'h000708700807, 48'h006151494543, 48'h00007F414100,
    48'h0015167C1615, 48'h000041417F00, 48'h000402010204, 48'h004040404040,
    48'h000001020400, 48'h002054545478, 48'h007F48444438, 48'h003844444420,
    48'h00384444487F, 48'h003854545418, 48'h00087E090102, 48'h000C5252523E,
    48'h007F08040478, 48'h0000447D4000, 48'h002040443D00, 48'h007F10284400,
    48'h0000417F4000, 48'h007C04180478, 48'h007C08040478, 48'h003844444438,
    48'h007C14141408, 48'h00081414187C, 48'h007C08040408, 48'h004854545420,
    48'h00043F444020, 48'h003C4040207C, 48'h001C2040201C, 48'h003C4030403C,
    48'h004428102844, 48'h000C5050503C, 48'h004464544C44, 48'h000008364100,
    48'h0000007F0000, 48'h000041360800, 48'h0008082A1C08, 48'h00081C2A0808
  };

  // Glyph row lookup; indexes past the table read as blank
  function automatic logic [47:0] glyph_row(input logic [6:0] idx);
    logic [47:0] row;
    row = '0;
    if (idx < 7'(ROM_GLYPHS)) begin
      row = GLYPH_ROM[idx];
    end
    return row;
  endfunction

  // Column select; columns past the sixth read as blank
  function automatic logic [7:0] glyph_col(input logic [47:0] row, input logic [2:0] c);
    logic [7:0] col;
    case (c)
      3'd0: col = row[47:40];
      3'd1: col = row[39:32];
      3'd2: col = row[31:24];
      3'd3: col = row[23:16];
      3'd4: col = row[15:8];
      3'd5: col = row[7:0];
      default: col = 8'h00;
    endcase
    return col;
  endfunction

endpackage

`default_nettype wire

@@ sv/ptlr_front.sv @@
// Front end: accepts input transfers, classifies them and queues the work.
`default_nettype none

module ptlr_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [15:0]       in_tdata,   // [7:0] char_code, [15:8] start_col
  input  wire logic [1:0]        in_tuser,   // [1:0] func
  output logic                   q_valid,
  output ptlr_pkg::q_entry_t     q_entry,
  input  wire logic              q_pop
);
  import ptlr_pkg::*;

  q_entry_t   mem_r [QUEUE_DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  logic       push;
  logic       pop;
  logic [7:0] glyph_idx;
  q_entry_t   new_entry;

  // Classify: blank-like codes become a space run, unknown func is dropped
  always_comb begin
    glyph_idx = in_tdata[7:0] - FIRST_CODE;
    new_entry.arg = 8'h00;
    case (func_t'(in_tuser))
      FUNC_START: begin
        new_entry.kind = KIND_START;
        new_entry.arg  = in_tdata[15:8];
      end
      FUNC_CHAR: begin
        if (glyph_idx == 8'h00 || glyph_idx >= 8'(ROM_GLYPHS)) begin
          new_entry.kind = KIND_SPACE;
        end else begin
          new_entry.kind = KIND_GLYPH;
          new_entry.arg  = glyph_idx;
        end
      end
      FUNC_END: new_entry.kind = KIND_END;
      default:  new_entry.kind = KIND_END;
    endcase
  end

  assign in_tready = (cnt_r != 2'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready && (func_t'(in_tuser) != FUNC_NONE);
  assign pop       = q_pop && q_valid;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_entry   = mem_r[rd_ptr_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_entry;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(QUEUE_DEPTH)) else $error("queue overfilled");
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1) else $error("push lost");
  a_pop_only_filled: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ sv/ptlr_back.sv @@
// Back end: walks glyph columns, tracks the line column and drives the result register.
`default_nettype none

module ptlr_back #(
  parameter int unsigned LINE_COLUMNS = 128,
  parameter int unsigned GLYPH_WIDTH  = 6
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire ptlr_pkg::q_entry_t q_entry,
  output logic                    q_pop,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [15:0]             out_tdata,  // [7:0] column_byte, [15:8] repeat_count
  output logic                    out_tlast   // last_of_run
);
  import ptlr_pkg::*;

  localparam logic [7:0] LC      = 8'(LINE_COLUMNS);
  localparam logic [2:0] GW_LAST = 3'(GLYPH_WIDTH - 1);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_COLS     = 4'b0010,
    S_SPACER   = 4'b0100,
    S_END_MARK = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  logic [2:0]  col_idx_r, col_idx_nxt;
  logic [47:0] row_r, row_nxt;
  logic [7:0]  count_r, count_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic [7:0]  out_rep_r, out_rep_nxt;
  logic        out_last_r, out_last_nxt;

  logic        slot_free;
  logic        emit;
  logic [7:0]  e_byte;
  logic [7:0]  e_rep;
  logic        e_last;
  logic [7:0]  col;
  logic        want;
  logic [7:0]  count_inc1;
  logic [8:0]  sum3;
  logic [7:0]  count_inc3;

  assign slot_free  = !out_valid_r || out_tready;
  assign col        = glyph_col(row_r, col_idx_r);
  assign want       = (col != 8'h00) && (count_r < LC);
  assign count_inc1 = (count_r == 8'hFF) ? 8'hFF : count_r + 8'd1;
  assign sum3       = {1'b0, count_r} + {1'b0, SPACE_BLANKS};
  assign count_inc3 = sum3[8] ? 8'hFF : sum3[7:0];

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    col_idx_nxt = col_idx_r;
    row_nxt     = row_r;
    count_nxt   = count_r;
    q_pop       = 1'b0;
    emit        = 1'b0;
    e_byte      = 8'h00;
    e_rep       = 8'd1;
    e_last      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          case (q_entry.kind)
            KIND_GLYPH: begin
              q_pop       = 1'b1;
              row_nxt     = glyph_row(q_entry.arg[6:0]);
              col_idx_nxt = 3'd0;
              state_nxt   = S_COLS;
            end
            KIND_START: begin
              if (slot_free) begin
                q_pop     = 1'b1;
                count_nxt = q_entry.arg;
                emit      = (q_entry.arg != 8'h00);
                e_rep     = q_entry.arg;
                e_last    = 1'b1;
              end
            end
            KIND_SPACE: begin
              if (slot_free) begin
                q_pop     = 1'b1;
                count_nxt = count_inc3;
                emit      = 1'b1;
                e_rep     = SPACE_BLANKS;
                e_last    = 1'b1;
              end
            end
            KIND_END: begin
              if (slot_free) begin
                q_pop = 1'b1;
                emit  = 1'b1;
                if (count_r < LC) begin
                  e_rep     = LC - count_r;
                  state_nxt = S_END_MARK;
                end else begin
                  e_byte = END_MARK;
                  e_last = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_COLS: begin
        if (!want || slot_free) begin
          if (want) begin
            emit      = 1'b1;
            e_byte    = col;
            count_nxt = count_inc1;
          end
          if (col_idx_r == GW_LAST) begin
            state_nxt = S_SPACER;
          end else begin
            col_idx_nxt = col_idx_r + 3'd1;
          end
        end
      end
      S_SPACER: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_last    = 1'b1;
          count_nxt = count_inc1;
          state_nxt = S_IDLE;
        end
      end
      S_END_MARK: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_byte    = END_MARK;
          e_last    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result register: loads on emit, empties once the transfer completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_rep_nxt   = out_rep_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = e_byte;
      out_rep_nxt   = e_rep;
      out_last_nxt  = e_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_idx_r  <= col_idx_nxt;
    row_r      <= row_nxt;
    out_byte_r <= out_byte_nxt;
    out_rep_r  <= out_rep_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_rep_r, out_byte_r};
  assign out_tlast  = out_last_r;

  a_pop_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE) else $error("queue popped mid-item");
  a_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_rep_r != 8'h00) else $error("empty run emitted");
  a_cols_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COLS |=> count_r >= $past(count_r)) else $error("column count fell");
  a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> slot_free) else $error("result overwritten");

endmodule

`default_nettype wire

@@ sv/proportional_text_line_renderer.sv @@
// Top level: proportional text line renderer, front end, work queue and back end.
// An accepted item is queued; the back end takes it from the queue head. A start, space or
// end item registers its first run as it is popped; a glyph loads its row first.
// A character passes S_IDLE, S_COLS per glyph column, then S_SPACER; start and space items
// end in S_IDLE, an end item in S_IDLE or S_END_MARK; the 2-entry queue overlaps them.
// Reset (rst_n low, synchronous) empties the queue and result register and zeroes the column.
`default_nettype none

module proportional_text_line_renderer #(
  parameter int unsigned LINE_COLUMNS = 128,
  parameter int unsigned GLYPH_WIDTH  = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] char_code, [15:8] start_col
  input  wire logic [1:0]  in_tuser,   // [1:0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] column_byte, [15:8] repeat_count
  output logic             out_tlast   // last_of_run
);
  import ptlr_pkg::*;

  logic     q_valid;
  q_entry_t q_entry;
  logic     q_pop;

  ptlr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop)
  );

  ptlr_back #(
    .LINE_COLUMNS (LINE_COLUMNS),
    .GLYPH_WIDTH  (GLYPH_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

@@ tb/sv/proportional_text_line_renderer_tb.sv @@
// Self-checking testbench for the proportional text line renderer.
module proportional_text_line_renderer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptlr_pkg::*;

  localparam int unsigned LINE_COLS   = 128;
  localparam int unsigned GLYPH_COLS  = 6;
  localparam int unsigned FONT_COLS   = 6;
  localparam int unsigned FONT_GLYPHS = 96;
  localparam logic [7:0]  CODE_BASE   = 8'h20;
  localparam logic [7:0]  TERM_BYTE   = 8'hE3;
  localparam logic [7:0]  BLANK_RUN   = 8'd3;
  localparam int unsigned ITEM_TARGET = 370;
  localparam int unsigned QUIET_TAIL  = 60;
  localparam int unsigned DRAIN_WAIT  = 50;
  localparam int unsigned STALL_LIMIT = 300;
  localparam int unsigned PRINT_LIMIT = 50;

  // Font rows, column 0 in the top byte
  localparam logic [47:0] FONT [FONT_GLYPHS] = '{
    48'h000000000000, 48'h0000004F0000, 48'h000007000700, 48'h00147F147F14,
    48'h00242A7F2A12, 48'h002313086462, 48'h003649552250, 48'h000005030000,
    48'h00001C224100, 48'h000041221C00, 48'h0014083E0814, 48'h0008083E0808,
    48'h000050300000, 48'h000808080808, 48'h000060600000, 48'h002010080402,
    48'h003E5149453E, 48'h0000427F4000, 48'h004261514946, 48'h002141454B31,
    48'h001814127F10, 48'h002745454539, 48'h003C4A494930, 48'h000171090503,
    48'h003649494936, 48'h00064949291E, 48'h000036360000, 48'h000056360000,
    48'h000814224100, 48'h001414141414, 48'h000041221408, 48'h000201510906,
    48'h00324979413E, 48'h007E1111117E, 48'h007F49494936, 48'h003E41414122,
    48'h007F4141221C, 48'h007F49494941, 48'h007F09090901, 48'h003E4149497A,
    48'h007F0808087F, 48'h0000417F4100, 48'h002040413F01, 48'h007F08142241,
    48'h007F40404040, 48'h007F020C027F, 48'h007F0408107F, 48'h003E4141413E,
    48'h007F09090906, 48'h003E4151215E, 48'h007F09192946, 48'h004649494931,
    48'h0001017F0101, 48'h003F4040403F, 48'h001F2040201F, 48'h003F4038403F,
    48'h006314081463, 48'h000708700807, 48'h006151494543, 48'h00007F414100,
    48'h0015167C1615, 48'h000041417F00, 48'h000402010204, 48'h004040404040,
    48'h000001020400, 48'h002054545478, 48'h007F48444438, 48'h003844444420,
    48'h00384444487F, 48'h003854545418, 48'h00087E090102, 48'h000C5252523E,
    48'h007F08040478, 48'h0000447D4000, 48'h002040443D00, 48'h007F10284400,
    48'h0000417F4000, 48'h007C04180478, 48'h007C08040478, 48'h003844444438,
    48'h007C14141408, 48'h00081414187C, 48'h007C08040408, 48'h004854545420,
    48'h00043F444020, 48'h003C4040207C, 48'h001C2040201C, 48'h003C4030403C,
    48'h004428102844, 48'h000C5050503C, 48'h004464544C44, 48'h000008364100,
    48'h0000007F0000, 48'h000041360800, 48'h0008082A1C08, 48'h00081C2A0808
  };

  typedef struct {
    func_t      func;
    logic [7:0] code;
    logic [7:0] offs;
  } text_item_t;

  typedef struct packed {
    logic [7:0] column_byte;
    logic [7:0] repeat_count;
    logic       last_flag;
  } col_run_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [15:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [15:0] out_tdata;
  logic        out_tlast;

  text_item_t  text_items[$];
  col_run_t    expected_runs[$];
  int unsigned line_col   = 0;
  int unsigned mismatches = 0;
  int unsigned item_total = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  bit          quiet      = 1'b0;
  text_item_t  next_item;
  col_run_t    want;

  proportional_text_line_renderer #(
    .LINE_COLUMNS(LINE_COLS),
    .GLYPH_WIDTH (GLYPH_COLS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
  endtask

  function automatic int unsigned sat_col(input int unsigned cols);
    return (cols > 255) ? 255 : cols;
  endfunction

  // Column runs caused by one text item; updates the line position
  task automatic render_item(input func_t f, input logic [7:0] code, input logic [7:0] offs);
    col_run_t    runs[$];
    logic [7:0]  idx;
    logic [7:0]  colv;
    int unsigned c;
    case (f)
      FUNC_START: begin
        line_col = offs;
        if (offs != 8'd0) begin
          runs.push_back('{8'h00, offs, 1'b0});
        end
      end
      FUNC_CHAR: begin
        idx = code - CODE_BASE;
        if (idx == 8'd0 || idx >= FONT_GLYPHS) begin
          // blank or unmapped code: fixed-width gap, never clipped
          runs.push_back('{8'h00, BLANK_RUN, 1'b0});
          line_col = sat_col(line_col + BLANK_RUN);
        end else begin
          for (c = 0; c < GLYPH_COLS; c++) begin
            colv = (c < FONT_COLS) ? FONT[idx][47 - 8 * c -: 8] : 8'h00;
            if (colv != 8'h00 && line_col < LINE_COLS) begin
              runs.push_back('{colv, 8'd1, 1'b0});
              line_col = sat_col(line_col + 1);
            end
          end
          // spacer column always goes out
          runs.push_back('{8'h00, 8'd1, 1'b0});
          line_col = sat_col(line_col + 1);
        end
      end
      FUNC_END: begin
        if (line_col < LINE_COLS) begin
          runs.push_back('{8'h00, 8'(LINE_COLS - line_col), 1'b0});
        end
        runs.push_back('{TERM_BYTE, 8'd1, 1'b0});
      end
      default: ;
    endcase
    if (runs.size() > 0) begin
      runs[runs.size() - 1].last_flag = 1'b1;
    end
    foreach (runs[i]) expected_runs.push_back(runs[i]);
  endtask

  // Driver: presents queued text items, with random gaps between transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        render_item(func_t'(in_tuser), in_tdata[7:0], in_tdata[15:8]);
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (text_items.size() > 0) begin
          next_item = text_items.pop_front();
          quiet = (text_items.size() < QUIET_TAIL);
          in_tuser  <= next_item.func;
          in_tdata  <= {next_item.offs, next_item.code};
          in_tvalid <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(1, 7);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each run transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_runs.size() == 0) begin
          report_mismatch($sformatf("unexpected run byte %02h x%0d last %0b",
                                    out_tdata[7:0], out_tdata[15:8], out_tlast));
        end else begin
          want = expected_runs.pop_front();
          if (out_tdata[7:0] !== want.column_byte) begin
            report_mismatch($sformatf("column_byte %02h, expected %02h",
                                      out_tdata[7:0], want.column_byte));
          end
          if (out_tdata[15:8] !== want.repeat_count) begin
            report_mismatch($sformatf("repeat_count %0d, expected %0d",
                                      out_tdata[15:8], want.repeat_count));
          end
          if (out_tlast !== want.last_flag) begin
            report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                      out_tlast, want.last_flag));
          end
        end
      end
      // backpressure bursts
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 7);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic add_item(input func_t f, input logic [7:0] code, input logic [7:0] offs);
    text_items.push_back('{f, code, offs});
    if (f != FUNC_NONE) begin
      item_total++;
    end
  endtask

  // Mostly printable glyphs, some blanks and unmapped codes
  function automatic logic [7:0] pick_code();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return 8'($urandom_range(8'h21, 8'h7E));
    if (roll < 87) return CODE_BASE;
    if (roll < 90) return 8'h7F;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int unsigned n;
    logic [7:0]  offs;

    // directed: edge codes, ignored function, clipping and saturation
    add_item(FUNC_START, 8'hFF, 8'd0);
    add_item(FUNC_CHAR, 8'h20, 8'h00);
    add_item(FUNC_CHAR, 8'h00, 8'hFF);
    add_item(FUNC_CHAR, 8'hFF, 8'h00);
    add_item(FUNC_CHAR, 8'h7F, 8'hAA);
    add_item(FUNC_CHAR, 8'h21, 8'h55);
    add_item(FUNC_CHAR, 8'h1F, 8'h00);
    add_item(FUNC_CHAR, 8'h80, 8'h00);
    add_item(FUNC_NONE, 8'hFF, 8'hFF);
    add_item(FUNC_END, 8'h00, 8'h00);
    add_item(FUNC_START, 8'h00, 8'd255);
    add_item(FUNC_CHAR, 8'h41, 8'h00);
    add_item(FUNC_CHAR, 8'h20, 8'h00);
    add_item(FUNC_END, 8'hFF, 8'hFF);
    add_item(FUNC_START, 8'h00, 8'd120);
    add_item(FUNC_CHAR, 8'h57, 8'h00);
    add_item(FUNC_CHAR, 8'h23, 8'h00);
    add_item(FUNC_END, 8'h00, 8'h00);
    add_item(FUNC_START, 8'h00, 8'd127);
    add_item(FUNC_END, 8'h00, 8'h00);
    add_item(FUNC_START, 8'h00, 8'd128);
    add_item(FUNC_END, 8'h00, 8'h00);
    // character and end with no fresh start
    add_item(FUNC_CHAR, 8'h41, 8'h00);
    add_item(FUNC_END, 8'h00, 8'h00);

    // random: well-formed lines with random content, plus noise
    while (item_total < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        add_item(func_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          offs = 8'($urandom_range(60, 255));
        end else begin
          offs = 8'($urandom_range(0, 24));
        end
        add_item(FUNC_START, 8'($urandom_range(0, 255)), offs);
        n = $urandom_range(1, 14);
        repeat (n) add_item(FUNC_CHAR, pick_code(), 8'($urandom_range(0, 255)));
        // occasionally leave the line unterminated
        if ($urandom_range(0, 7) != 0) begin
          add_item(FUNC_END, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // drain, then let any stray runs show up
    while (text_items.size() != 0 || in_tvalid || expected_runs.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
